// ===== rtl/core/p2fl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the power-of-two free-list allocator core.
// No dependencies.

package p2fl_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int unsigned POOL_BYTES_DEF  = 2097152;
    localparam int unsigned NUM_CLASSES_DEF = 16;
    localparam int unsigned CHUNK_BYTES_DEF = 65536;

    // Block size limits: classes 2 (4 bytes) to 15 (32768 bytes).
    localparam int unsigned MAX_BLOCK  = 32768;
    localparam int unsigned MIN_CLASS  = 2;
    localparam int unsigned MAX_CLASS  = 15;
    localparam int unsigned CLS_CODE_W = 4;

    localparam logic [31:0] POOL_BASE_RST = 32'h0800_0000;

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_FREED    = 2'd2,
        ST_FOREIGN  = 2'd3
    } status_t;

endpackage

// ===== rtl/core/pow2_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
// Power-of-two segregated free-list pool allocator, top level.
// Depends on p2fl_pkg.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  request   | start, busy, req_type, req_size, free_addr | taken when start & !busy
//  result    | result_valid, block_addr, status           | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_data             | written when valid & ready
//
//  - A result word appears on the cycle after its request is taken.
//  - Free, fallback, foreign and carve allocations leave busy low, so a new
//    request can follow at once. A pop from a non-empty list passes through S_POP
//    with busy high: the link memory read is registered, and the head is rewritten from it.
//  - Reset clears all per-class state at once; the link memory needs no clear.
//  - The receiver cannot stall; cfg_ready is always high.

module pow2_free_list_allocator_core #(
    parameter int unsigned POOL_BYTES  = p2fl_pkg::POOL_BYTES_DEF,
    parameter int unsigned NUM_CLASSES = p2fl_pkg::NUM_CLASSES_DEF,
    parameter int unsigned CHUNK_BYTES = p2fl_pkg::CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] req_size,
    input  logic [31:0] free_addr,
    // result
    output logic        result_valid,
    output logic [31:0] block_addr,
    output logic [1:0]  status,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import p2fl_pkg::*;

    // Derived sizes
    localparam int unsigned REGION_BYTES = POOL_BYTES / NUM_CLASSES;
    localparam int unsigned LINK_WORDS   = POOL_BYTES / 4;
    localparam int unsigned OFF_W        = $clog2(POOL_BYTES);
    localparam int unsigned WRD_W        = OFF_W - 2;
    localparam int unsigned LW_W         = $clog2(LINK_WORDS);
    localparam int unsigned RN_W         = $clog2(POOL_BYTES + 2 * CHUNK_BYTES + 1);
    localparam int unsigned CNT_W        = $clog2(CHUNK_BYTES / 4 + 1);
    localparam int unsigned CLS_W        = $clog2(NUM_CLASSES);
    localparam int unsigned FK_W         = $clog2(NUM_CLASSES + 1);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    // End offset (exclusive) of region k.
    function automatic logic [RN_W-1:0] region_end(input logic [CLS_W-1:0] k);
        return RN_W'((32'(k) + 32'd1) * 32'(REGION_BYTES));
    endfunction

    // Registers
    state_t             state_reg;
    logic               result_valid_reg;
    logic [31:0]        block_addr_reg;
    status_t            status_reg;
    logic [31:0]        pool_base_reg;
    logic [CLS_W-1:0]   pop_k_reg;
    logic [OFF_W:0]     link_rdata_reg;

    // Per-class state, one entry per region
    logic [OFF_W-1:0]   head_reg        [NUM_CLASSES];
    logic               head_vld_reg    [NUM_CLASSES];
    logic [OFF_W-1:0]   carve_base_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]   carve_rem_reg   [NUM_CLASSES];
    logic [RN_W-1:0]    region_next_reg [NUM_CLASSES];
    logic               exhausted_reg   [NUM_CLASSES];

    // Link memory: {valid, next offset} per 4-byte word of the pool
    logic [OFF_W:0]     link_mem [LINK_WORDS];

    // Next values and decode
    state_t             state_next;
    logic [31:0]        block_addr_next;
    status_t            status_next;

    logic               accept;
    logic [CLS_CODE_W-1:0] cls;
    logic [CLS_CODE_W-1:0] ak;
    logic               alloc_ok;
    logic [31:0]        foff;
    logic [FK_W-1:0]    fk;
    logic               free_ok;
    logic [CLS_W-1:0]   k_sel;
    logic [WRD_W-1:0]   hword;
    logic [WRD_W-1:0]   fword;
    logic [CNT_W-1:0]   n_blocks;
    logic [CNT_W-1:0]   rem_sel;
    logic [OFF_W-1:0]   base_sel;
    logic [OFF_W-1:0]   blk_off;
    logic [OFF_W-1:0]   alloc_off;
    logic [RN_W-1:0]    rn_adv;

    logic               link_we;
    logic [LW_W-1:0]    link_waddr;
    logic [OFF_W:0]     link_wdata;
    logic               link_re;
    logic [LW_W-1:0]    link_raddr;

    logic               head_we;
    logic [CLS_W-1:0]   head_k;
    logic [OFF_W-1:0]   head_wval;
    logic               head_wvld;
    logic               carve_we;
    logic [OFF_W-1:0]   carve_base_wval;
    logic [CNT_W-1:0]   carve_rem_wval;
    logic               chunk_we;
    logic               exh_wval;

    assign busy      = (state_reg == S_POP);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign result_valid = result_valid_reg;
    assign block_addr   = block_addr_reg;
    assign status       = status_reg;

    // Request decode: class, region of a freed address, carve arithmetic
    always_comb
    begin
        // smallest class whose block holds the request
        cls = CLS_CODE_W'(MAX_CLASS);
        for (int c = MAX_CLASS - 1; c >= int'(MIN_CLASS); c--)
        begin
            if (17'(req_size) <= 17'(32'd1 << c))
            begin
                cls = CLS_CODE_W'(c);
            end
        end
        ak       = cls - CLS_CODE_W'(MIN_CLASS);
        alloc_ok = (req_size != 16'd0) && (32'(req_size) <= MAX_BLOCK)
                   && (32'(ak) < NUM_CLASSES);

        // region holding a freed offset; NUM_CLASSES means the unused tail
        foff = free_addr - pool_base_reg;
        fk   = '0;
        for (int j = 1; j <= int'(NUM_CLASSES); j++)
        begin
            if (foff >= 32'(j) * 32'(REGION_BYTES))
            begin
                fk = FK_W'(j);
            end
        end
        free_ok = (foff < 32'(POOL_BYTES)) && (32'(fk) < NUM_CLASSES);

        k_sel = (req_type == REQ_FREE) ? fk[CLS_W-1:0] : ak[CLS_W-1:0];
        hword = head_reg[k_sel][OFF_W-1:2];
        fword = foff[OFF_W-1:2];

        // carving: fresh chunk when the current one is used up
        n_blocks = CNT_W'(32'(CHUNK_BYTES) >> cls);
        if (n_blocks == '0)
        begin
            n_blocks = CNT_W'(1);
        end
        if (carve_rem_reg[k_sel] == '0)
        begin
            rem_sel  = n_blocks - CNT_W'(1);
            base_sel = region_next_reg[k_sel][OFF_W-1:0];
        end
        else
        begin
            rem_sel  = carve_rem_reg[k_sel] - CNT_W'(1);
            base_sel = carve_base_reg[k_sel];
        end
        blk_off   = OFF_W'(32'(rem_sel) << cls);
        alloc_off = base_sel + blk_off;
        rn_adv    = region_next_reg[k_sel] + RN_W'(CHUNK_BYTES);
    end

    // Action select: result word, per-class updates, link memory access
    always_comb
    begin
        state_next      = state_reg;
        block_addr_next = '0;
        status_next     = ST_FALLBACK;

        link_we    = 1'b0;
        link_waddr = fword[LW_W-1:0];
        link_wdata = {head_vld_reg[k_sel], head_reg[k_sel]};
        link_re    = 1'b0;
        link_raddr = hword[LW_W-1:0];

        head_we         = 1'b0;
        head_k          = k_sel;
        head_wval       = '0;
        head_wvld       = 1'b0;
        carve_we        = 1'b0;
        carve_base_wval = base_sel;
        carve_rem_wval  = rem_sel;
        chunk_we        = 1'b0;
        exh_wval        = (rn_adv + RN_W'(CHUNK_BYTES)) > region_end(k_sel);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        if (free_ok)
                        begin
                            status_next = ST_FREED;
                            link_we     = (32'(fword) < LINK_WORDS);
                            head_we     = 1'b1;
                            head_wval   = foff[OFF_W-1:0];
                            head_wvld   = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FOREIGN;
                        end
                    end
                    else if (alloc_ok)
                    begin
                        if (head_vld_reg[k_sel])
                        begin
                            // pop: result now, head rewritten next cycle
                            status_next     = ST_ALLOC;
                            block_addr_next = pool_base_reg + 32'(head_reg[k_sel]);
                            if (32'(hword) < LINK_WORDS)
                            begin
                                link_re    = 1'b1;
                                state_next = S_POP;
                            end
                            else
                            begin
                                head_we = 1'b1;
                            end
                        end
                        else if (carve_rem_reg[k_sel] != '0
                                 || !exhausted_reg[k_sel])
                        begin
                            status_next     = ST_ALLOC;
                            block_addr_next = pool_base_reg + 32'(alloc_off);
                            carve_we        = 1'b1;
                            chunk_we        = (carve_rem_reg[k_sel] == '0);
                        end
                    end
                end
            end
            S_POP:
            begin
                head_we    = 1'b1;
                head_k     = pop_k_reg;
                head_wval  = link_rdata_reg[OFF_W-1:0];
                head_wvld  = link_rdata_reg[OFF_W];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            block_addr_reg   <= '0;
            status_reg       <= ST_ALLOC;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= accept;
            if (accept)
            begin
                block_addr_reg <= block_addr_next;
                status_reg     <= status_next;
            end
        end
    end

    // Configuration register and pop context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RST;
            pop_k_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pool_base_reg <= cfg_data;
            end
            if (link_re)
            begin
                pop_k_reg <= k_sel;
            end
        end
    end

    // Per-class list heads and carve state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < int'(NUM_CLASSES); j++)
            begin
                head_reg[j]        <= '0;
                head_vld_reg[j]    <= 1'b0;
                carve_base_reg[j]  <= '0;
                carve_rem_reg[j]   <= '0;
                region_next_reg[j] <= RN_W'(32'(j) * 32'(REGION_BYTES));
                exhausted_reg[j]   <= 1'b0;
            end
        end
        else
        begin
            if (head_we)
            begin
                head_reg[head_k]     <= head_wval;
                head_vld_reg[head_k] <= head_wvld;
            end
            if (carve_we)
            begin
                carve_base_reg[k_sel] <= carve_base_wval;
                carve_rem_reg[k_sel]  <= carve_rem_wval;
            end
            if (chunk_we)
            begin
                region_next_reg[k_sel] <= rn_adv;
                exhausted_reg[k_sel]   <= exh_wval;
            end
        end
    end

    // Link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    // Checks
    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> state_reg == S_IDLE)
        else $error("pop phase lasted more than one cycle");

    a_pop_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> result_valid_reg && status_reg == ST_ALLOC)
        else $error("pop phase without an allocation result");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted request produced no result");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && status_reg != ST_ALLOC |-> block_addr_reg == 32'd0)
        else $error("nonzero address on a non-allocation result");

    a_no_accept_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        link_re |=> !accept)
        else $error("request taken while head update pending");

endmodule
